>>> hw/rtl/olpe_pkg.sv
// Package for the ordered list positional edit unit.
// Holds operation and status codes, sequencer states and the result beat type.
// No dependencies.
`default_nettype none

package olpe_pkg;

  // Fixed field widths of the channel payloads.
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;

  // Operation codes carried by func. Codes above OP_DUMP act as a count.
  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_COUNT  = 3'd3,
    OP_DUMP   = 3'd4
  } olpe_op_e;

  // Status codes of a result beat.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } olpe_status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_RESULT
  } olpe_state_e;

  // One result beat.
  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic [COUNT_W-1:0]        entry_count;
    olpe_status_e              status;
    logic                      last;
  } olpe_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/olpe_if.sv
// Channel interfaces of the ordered list positional edit unit.
// Depends on olpe_pkg for the payload widths.
`default_nettype none

// Command channel: one beat carries one list operation.
interface olpe_in_if;
  import olpe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

// Result channel: one beat per result.
interface olpe_out_if;
  import olpe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] item_value;
  logic [COUNT_W-1:0]        entry_count;
  logic [STAT_W-1:0]         status;
  logic                      last;

  modport source (output valid, output item_value, output entry_count, output status,
                  output last, input ready);
  modport sink   (input valid, input item_value, input entry_count, input status,
                  input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ordered_list_positional_edit_unit.sv
// Ordered list of up to DEPTH signed 32-bit values, edited by 1-based position.
// One command is worked on at a time; the command port is ready only while the
// sequencer is idle. All entry moves go through one store with a write port and
// a registered read port, so each moved entry takes a read state and a write state.
// Each result waits in an output register, which frees the sequencer for the
// next command as soon as the final beat is loaded there.
// Depends on olpe_pkg, olpe_if, olpe_store and olpe_ctrl.
`default_nettype none

module ordered_list_positional_edit_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  olpe_in_if.sink   in_i,
  olpe_out_if.source out_o
);
  import olpe_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                      res_valid;
  logic                      res_ready;
  olpe_res_t                 res;
  logic                      wr_en;
  logic [AddrW-1:0]          wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [AddrW-1:0]          rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  logic      out_valid_q;
  olpe_res_t out_beat_q;

  olpe_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_func_i     (in_i.func),
    .in_value_i    (in_i.value),
    .in_position_i (in_i.position),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data)
  );

  olpe_store #(.DEPTH(DEPTH)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Output register: takes a beat when empty or being drained.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_beat_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.item_value  = out_beat_q.item_value;
  assign out_o.entry_count = out_beat_q.entry_count;
  assign out_o.status      = out_beat_q.status;
  assign out_o.last        = out_beat_q.last;

endmodule

`default_nettype wire

>>> hw/rtl/olpe_store.sv
// Entry storage of the ordered list: one write port, one registered read port.
// Depends on olpe_pkg for the value width.
`default_nettype none

module olpe_store #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               wr_en_i,
  input  wire logic [AddrW-1:0]                   wr_addr_i,
  input  wire logic signed [olpe_pkg::VALUE_W-1:0] wr_data_i,
  input  wire logic                               rd_en_i,
  input  wire logic [AddrW-1:0]                   rd_addr_i,
  output      logic signed [olpe_pkg::VALUE_W-1:0] rd_data_o
);
  import olpe_pkg::*;

  logic signed [VALUE_W-1:0] mem_q [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/olpe_ctrl.sv
// Sequencer of the ordered list: decodes a command, moves entries one at a
// time through the store with a shared index step unit, and issues result beats.
// Depends on olpe_pkg.
`default_nettype none

module olpe_ctrl #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Command side.
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [olpe_pkg::FUNC_W-1:0]         in_func_i,
  input  wire logic signed [olpe_pkg::VALUE_W-1:0] in_value_i,
  input  wire logic [olpe_pkg::POS_W-1:0]          in_position_i,
  // Result side.
  output      logic                                res_valid_o,
  input  wire logic                                res_ready_i,
  output      olpe_pkg::olpe_res_t                 res_o,
  // Store port.
  output      logic                                wr_en_o,
  output      logic [AddrW-1:0]                    wr_addr_o,
  output      logic signed [olpe_pkg::VALUE_W-1:0] wr_data_o,
  output      logic                                rd_en_o,
  output      logic [AddrW-1:0]                    rd_addr_o,
  input  wire logic signed [olpe_pkg::VALUE_W-1:0] rd_data_i
);
  import olpe_pkg::*;

  olpe_state_e               state_q, state_d;
  logic [FUNC_W-1:0]         op_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]          pos_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [AddrW-1:0]          idx_q, idx_d;
  olpe_status_e              status_q, status_d;

  // Shared index unit: the index plus or minus one.
  logic            step_dec;
  logic [CntW-1:0] step_sum;
  logic [AddrW-1:0] step_idx;

  assign step_dec = (state_q == ST_INS_RD) || (state_q == ST_INS_WR);
  assign step_sum = CntW'(idx_q) + (step_dec ? {CntW{1'b1}} : CntW'(1));
  assign step_idx = step_sum[AddrW-1:0];

  // Position and fill checks.
  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   cnt_ext;
  logic [POS_W-1:0] pos_m1;
  logic             ins_bad, del_bad, is_full, is_empty;
  logic             ins_at_pos, del_done, dump_last;

  assign pos_ext    = {1'b0, pos_q};
  assign cnt_ext    = (POS_W + 1)'(cnt_q);
  assign pos_m1     = pos_q - POS_W'(1);
  assign ins_bad    = (pos_q == '0) || (pos_ext > cnt_ext + (POS_W + 1)'(1));
  assign del_bad    = (pos_q == '0) || (pos_ext > cnt_ext);
  assign is_full    = (cnt_q == CntW'(DEPTH));
  assign is_empty   = (cnt_q == '0);
  assign ins_at_pos = (POS_W'(idx_q) == pos_m1);
  assign del_done   = (step_sum >= cnt_q);
  assign dump_last  = (step_sum == cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (op_q)
          OP_INSERT: state_d = (ins_bad || is_full) ? ST_RESULT : ST_INS_RD;
          OP_DELETE: state_d = del_bad ? ST_RESULT : ST_DEL_RD;
          OP_DUMP:   state_d = is_empty ? ST_RESULT : ST_DUMP_RD;
          default:   state_d = ST_RESULT;
        endcase
      end
      ST_INS_RD:  state_d = ins_at_pos ? ST_RESULT : ST_INS_WR;
      ST_INS_WR:  state_d = ST_INS_RD;
      ST_DEL_RD:  state_d = del_done ? ST_RESULT : ST_DEL_WR;
      ST_DEL_WR:  state_d = ST_DEL_RD;
      ST_DUMP_RD: state_d = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (res_ready_i) state_d = dump_last ? ST_IDLE : ST_DUMP_RD;
      end
      ST_RESULT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{item_value: '0, entry_count: COUNT_W'(cnt_q), status: status_q, last: 1'b1};
    wr_en_o     = 1'b0;
    wr_addr_o   = idx_q;
    wr_data_o   = value_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = step_idx;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    status_d    = status_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DECODE: begin
        status_d = STAT_OK;
        case (op_q)
          OP_APPEND: begin
            if (is_full) begin
              status_d = STAT_FULL;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = cnt_q[AddrW-1:0];
              cnt_d     = cnt_q + CntW'(1);
            end
          end
          OP_INSERT: begin
            if (ins_bad) begin
              status_d = STAT_BADPOS;
            end else if (is_full) begin
              status_d = STAT_FULL;
            end else begin
              idx_d = cnt_q[AddrW-1:0];
            end
          end
          OP_DELETE: begin
            if (del_bad) status_d = STAT_BADPOS;
            else idx_d = pos_m1[AddrW-1:0];
          end
          OP_DUMP: begin
            if (is_empty) status_d = STAT_EMPTY;
            else idx_d = '0;
          end
          default: ;
        endcase
      end
      ST_INS_RD: begin
        // Either drop the new value into its slot or fetch the entry below.
        if (ins_at_pos) begin
          wr_en_o = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
        end else begin
          rd_en_o = 1'b1;
        end
      end
      ST_INS_WR: begin
        wr_en_o   = 1'b1;
        wr_data_o = rd_data_i;
        idx_d     = step_idx;
      end
      ST_DEL_RD: begin
        if (del_done) cnt_d = cnt_q - CntW'(1);
        else rd_en_o = 1'b1;
      end
      ST_DEL_WR: begin
        wr_en_o   = 1'b1;
        wr_data_o = rd_data_i;
        idx_d     = step_idx;
      end
      ST_DUMP_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = idx_q;
      end
      ST_DUMP_OUT: begin
        res_valid_o = 1'b1;
        res_o = '{item_value: rd_data_i, entry_count: COUNT_W'(cnt_q), status: STAT_OK,
                  last: dump_last};
        if (res_ready_i && !dump_last) idx_d = step_idx;
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= in_func_i;
      value_q <= in_value_i;
      pos_q   <= in_position_i;
    end
  end

`ifndef ASSERT_OFF
  // The entry count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above capacity");

  // A new command is never taken while a result beat is offered.
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid_o)
    else $error("command taken while a result is pending");

  // Store writes stay inside the array.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (CntW'(wr_addr_o) < CntW'(DEPTH)))
    else $error("store write beyond capacity");

  // A delivered final beat ends the command.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && res_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after final beat");

  // The count changes only while a command is being worked on.
  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(cnt_q))
    else $error("entry count changed while idle");
`endif

endmodule

`default_nettype wire
